// ===== hdl/flp_pkg.sv =====
// Shared types, constants and the digit decoder of the radix-prefixed literal parser.
package flp_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CHAR_WIDTH  = 7;
  localparam int unsigned BASE_WIDTH  = 6;
  localparam int unsigned POS_WIDTH   = 3;

  localparam logic [CHAR_WIDTH-1:0] CH_BIN   = 7'd37;  // '%'
  localparam logic [CHAR_WIDTH-1:0] CH_DEC   = 7'd35;  // '#'
  localparam logic [CHAR_WIDTH-1:0] CH_HEX   = 7'd36;  // '$'
  localparam logic [CHAR_WIDTH-1:0] CH_QUOTE = 7'd39;  // single quote
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 7'd57;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 7'd65;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 7'd90;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 7'd97;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 7'd122;
  localparam logic [CHAR_WIDTH-1:0] CASE_GAP   = 7'd32;
  localparam logic [CHAR_WIDTH-1:0] LETTER_OFFSET = 7'd10;

  localparam logic [BASE_WIDTH-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;

  localparam logic [POS_WIDTH-1:0] POS_FIRST  = 3'd0;
  localparam logic [POS_WIDTH-1:0] POS_SECOND = 3'd1;
  localparam logic [POS_WIDTH-1:0] POS_THIRD  = 3'd2;
  localparam logic [POS_WIDTH-1:0] POS_FOURTH = 3'd3;
  localparam logic [POS_WIDTH-1:0] POS_SAT    = 3'd4;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_BIN,
    PH_DEC,
    PH_DIGITS
  } flp_phase_e;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] token_char;
    logic                  last_char;
  } flp_in_t;

  typedef struct packed {
    logic                   is_valid;
    logic [VALUE_WIDTH-1:0] number_value;
  } flp_out_t;

  typedef struct packed {
    logic                  ok;
    logic [BASE_WIDTH-1:0] value;
  } flp_digit_t;

  // Decodes 0-9 and letters of either case into the values 0 to 35.
  function automatic flp_digit_t digit_value(input logic [CHAR_WIDTH-1:0] c);
    flp_digit_t            d;
    logic [CHAR_WIDTH-1:0] up;
    logic [CHAR_WIDTH-1:0] tmp;
    d   = '0;
    up  = c;
    tmp = '0;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      up = c - CASE_GAP;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      tmp     = c - CH_ZERO;
      d.ok    = 1'b1;
      d.value = tmp[BASE_WIDTH-1:0];
    end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
      tmp     = up - CH_UPPER_A + LETTER_OFFSET;
      d.ok    = 1'b1;
      d.value = tmp[BASE_WIDTH-1:0];
    end
    return d;
  endfunction

endpackage

// ===== hdl/forth_number_literal_parser_top.sv =====
// Top level of the radix-prefixed integer literal parser.
//
//   Channel  Direction  Payload     Handshake
//   in       input      flp_in_t    in_valid_i / in_stall_o
//   out      output     flp_out_t   out_valid_o / out_stall_i
//   cfg      input      base, 6 b   cfg_we_i, no wait
//
// One character is taken per clock while the input is not stalled; a character is held in the
// input register and its result, on the last character of a token, goes to the result register.
// The accumulator update (one 32 by 6 multiply and add) sets the per-cycle path.
// Reset clears the token state and sets the default base to ten.
// A stall on the output holds the result and back-pressures the input only while the
// result register is full; characters keep flowing whenever it can take a transfer.
module forth_number_literal_parser_top import flp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  flp_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output flp_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [BASE_WIDTH-1:0] cfg_data_i
);

  logic     item_valid;
  flp_in_t  item;
  logic     fire;
  logic     result_load;
  flp_out_t result;

  assign fire = item_valid && (!out_valid_o || !out_stall_i);

  flp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  flp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (fire),
    .item_i        (item),
    .result_load_o (result_load),
    .result_o      (result)
  );

  flp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (result_load),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_invalid_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_valid |-> out_data_o.number_value == '0)
    else $error("rejected token carries a non-zero value");

  a_stall_only_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid && out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could move");

  a_result_from_last_char : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire && item.last_char))
    else $error("result appeared without a last character");

  a_no_result_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !result_load)
    else $error("result overwritten while stalled");

endmodule

// ===== hdl/flp_in_reg.sv =====
// Input register that holds one accepted character until the parse core takes it.
module flp_in_reg import flp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  flp_in_t in_data_i,
  input  logic    take_i,
  output logic    item_valid_o,
  output flp_in_t item_o
);

  logic    valid_q;
  flp_in_t data_q;
  logic    ready;

  assign ready        = !valid_q || take_i;
  assign in_stall_o   = !ready;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ===== hdl/flp_core.sv =====
// Token state and the combinational update for one character, with the default base register.
module flp_core import flp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [BASE_WIDTH-1:0] cfg_data_i,
  input  logic                  fire_i,
  input  flp_in_t               item_i,
  output logic                  result_load_o,
  output flp_out_t              result_o
);

  logic [BASE_WIDTH-1:0]  default_base_q;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [BASE_WIDTH-1:0]  base_q, base_d;
  logic [POS_WIDTH-1:0]   pos_q, pos_d;
  flp_phase_e             phase_q, phase_d;
  logic                   failed_q, failed_d;
  logic                   first_quote_q, first_quote_d;
  logic [CHAR_WIDTH-1:0]  middle_q, middle_d;
  logic                   third_quote_q, third_quote_d;

  logic [BASE_WIDTH-1:0]             base_cur;
  flp_digit_t                        dig;
  logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
  logic                              quote_form;

  assign base_cur = (pos_q == POS_FIRST) ? default_base_q : base_q;
  assign dig      = digit_value(item_i.token_char);
  assign prod     = {{BASE_WIDTH{1'b0}}, acc_q} * {{VALUE_WIDTH{1'b0}}, base_cur};

  always_comb begin
    acc_d         = acc_q;
    base_d        = base_cur;
    phase_d       = phase_q;
    failed_d      = failed_q;
    first_quote_d = first_quote_q;
    middle_d      = middle_q;
    third_quote_d = third_quote_q;
    pos_d         = (pos_q == POS_SAT) ? pos_q : pos_q + 1'b1;

    case (pos_q)
      POS_FIRST:  first_quote_d = (item_i.token_char == CH_QUOTE);
      POS_SECOND: middle_d      = item_i.token_char;
      POS_THIRD:  third_quote_d = (item_i.token_char == CH_QUOTE);
      default:    ;
    endcase

    if (!failed_q) begin
      if (item_i.token_char == CH_BIN && phase_q == PH_NONE) begin
        base_d  = BASE_BIN;
        phase_d = PH_BIN;
      end else if (item_i.token_char == CH_DEC &&
                   (phase_q == PH_NONE || phase_q == PH_BIN)) begin
        base_d  = BASE_DEC;
        phase_d = PH_DEC;
      end else if (item_i.token_char == CH_HEX && phase_q != PH_DIGITS) begin
        base_d  = BASE_HEX;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_DIGITS;
        if (dig.ok && dig.value < base_cur) begin
          acc_d = prod[VALUE_WIDTH-1:0] + {{(VALUE_WIDTH-BASE_WIDTH){1'b0}}, dig.value};
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  assign quote_form    = (pos_d == POS_FOURTH) && first_quote_d && third_quote_d;
  assign result_load_o = fire_i && item_i.last_char;

  always_comb begin
    if (quote_form) begin
      result_o.is_valid     = 1'b1;
      result_o.number_value = {{(VALUE_WIDTH-CHAR_WIDTH){1'b0}}, middle_d};
    end else if (failed_d) begin
      result_o.is_valid     = 1'b0;
      result_o.number_value = '0;
    end else begin
      result_o.is_valid     = 1'b1;
      result_o.number_value = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      default_base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      base_q        <= BASE_RESET;
      pos_q         <= POS_FIRST;
      phase_q       <= PH_NONE;
      failed_q      <= 1'b0;
      first_quote_q <= 1'b0;
      middle_q      <= '0;
      third_quote_q <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last_char) begin
        acc_q         <= '0;
        base_q        <= default_base_q;
        pos_q         <= POS_FIRST;
        phase_q       <= PH_NONE;
        failed_q      <= 1'b0;
        first_quote_q <= 1'b0;
        middle_q      <= '0;
        third_quote_q <= 1'b0;
      end else begin
        acc_q         <= acc_d;
        base_q        <= base_d;
        pos_q         <= pos_d;
        phase_q       <= phase_d;
        failed_q      <= failed_d;
        first_quote_q <= first_quote_d;
        middle_q      <= middle_d;
        third_quote_q <= third_quote_d;
      end
    end
  end

endmodule

// ===== hdl/flp_out_reg.sv =====
// Result register that holds one parse result until the downstream side takes it.
module flp_out_reg import flp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  flp_out_t result_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output flp_out_t out_data_o
);

  logic     valid_q;
  flp_out_t data_q;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== tb/tb_forth_number_literal_parser_top.sv =====
// Self-checking testbench for the radix-prefixed literal parser, with a built-in predictor.
module tb_forth_number_literal_parser_top;
  import flp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  flp_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  flp_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [BASE_WIDTH-1:0] cfg_data = '0;

  int unsigned tx_idle_pct = 38;
  int unsigned rx_idle_pct = 38;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned chars_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  logic [BASE_WIDTH-1:0] base_setting = BASE_RESET;
  logic [CHAR_WIDTH-1:0] token_buf[$];

  // Predicted parser state.
  logic [BASE_WIDTH-1:0]  dflt_base = BASE_RESET;
  logic [VALUE_WIDTH-1:0] tok_acc = '0;
  logic [BASE_WIDTH-1:0]  tok_base = BASE_RESET;
  logic [POS_WIDTH-1:0]   tok_pos = POS_FIRST;
  flp_phase_e             tok_phase = PH_NONE;
  bit                     tok_bad = 1'b0;
  bit                     tok_q1 = 1'b0;
  bit                     tok_q3 = 1'b0;
  logic [CHAR_WIDTH-1:0]  tok_mid = '0;
  flp_out_t               pending_numbers[$];

  forth_number_literal_parser_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit char_digit(input logic [CHAR_WIDTH-1:0] c,
                                    output logic [BASE_WIDTH-1:0] v);
    logic [CHAR_WIDTH-1:0] up;
    logic [CHAR_WIDTH-1:0] tmp;
    v   = '0;
    up  = c;
    tmp = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      tmp = c - CH_ZERO;
      v   = tmp[BASE_WIDTH-1:0];
      return 1'b1;
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      up = c - CASE_GAP;
    end
    if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
      tmp = up - CH_UPPER_A + LETTER_OFFSET;
      v   = tmp[BASE_WIDTH-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic parse_char(input flp_in_t item);
    logic [CHAR_WIDTH-1:0] c;
    logic [BASE_WIDTH-1:0] dv;
    bit                    is_digit;
    flp_out_t              res;
    c = item.token_char;
    if (tok_pos == POS_FIRST) begin
      tok_base = dflt_base;
      tok_q1   = (c == CH_QUOTE);
    end else if (tok_pos == POS_SECOND) begin
      tok_mid = c;
    end else if (tok_pos == POS_THIRD) begin
      tok_q3 = (c == CH_QUOTE);
    end
    if (!tok_bad) begin
      if (c == CH_BIN && tok_phase == PH_NONE) begin
        tok_base  = BASE_BIN;
        tok_phase = PH_BIN;
      end else if (c == CH_DEC && tok_phase <= PH_BIN) begin
        tok_base  = BASE_DEC;
        tok_phase = PH_DEC;
      end else if (c == CH_HEX && tok_phase <= PH_DEC) begin
        tok_base  = BASE_HEX;
        tok_phase = PH_DIGITS;
      end else begin
        is_digit  = char_digit(c, dv);
        tok_phase = PH_DIGITS;
        if (is_digit && dv < tok_base) begin
          tok_acc = tok_acc * {26'd0, tok_base} + {26'd0, dv};
        end else begin
          tok_bad = 1'b1;
        end
      end
    end
    if (tok_pos < POS_SAT) begin
      tok_pos = tok_pos + 3'd1;
    end
    if (item.last_char) begin
      if (tok_pos == POS_FOURTH && tok_q1 && tok_q3) begin
        res.is_valid     = 1'b1;
        res.number_value = {25'd0, tok_mid};
      end else if (tok_bad) begin
        res = '0;
      end else begin
        res.is_valid     = 1'b1;
        res.number_value = tok_acc;
      end
      pending_numbers.push_back(res);
      tok_acc   = '0;
      tok_base  = dflt_base;
      tok_pos   = POS_FIRST;
      tok_phase = PH_NONE;
      tok_bad   = 1'b0;
      tok_q1    = 1'b0;
      tok_q3    = 1'b0;
      tok_mid   = '0;
    end
  endtask

  // Predicts on every input transfer and checks every output transfer.
  always @(posedge clk_i) begin
    flp_out_t exp_res;
    if (cfg_we) begin
      dflt_base = cfg_data;
    end
    if (in_valid && !in_stall) begin
      parse_char(in_data);
    end
    if (out_valid && !out_stall) begin
      if (pending_numbers.size() == 0) begin
        $error("unexpected result: is_valid %0d number_value 0x%08h",
               out_data.is_valid, out_data.number_value);
        err_cnt++;
      end else begin
        exp_res = pending_numbers.pop_front();
        if (out_data.is_valid !== exp_res.is_valid) begin
          $error("is_valid: expected %0d, actual %0d", exp_res.is_valid, out_data.is_valid);
          err_cnt++;
        end
        if (out_data.number_value !== exp_res.number_value) begin
          $error("number_value: expected 0x%08h, actual 0x%08h",
                 exp_res.number_value, out_data.number_value);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input bit last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {c, last};
    do @(posedge clk_i); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(CHAR_WIDTH'(s[i]), i == s.len() - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [BASE_WIDTH-1:0] b);
    wait_drained();
    cfg_we       <= 1'b1;
    cfg_data     <= b;
    base_setting  = b;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CHAR_WIDTH-1:0] random_digit(input int unsigned radix);
    int unsigned lim;
    int unsigned v;
    if (radix == 0 || $urandom_range(0, 19) == 0) begin
      lim = 36;
    end else begin
      lim = (radix > 36) ? 36 : radix;
    end
    v = $urandom_range(0, lim - 1);
    if (v < 10) begin
      return CH_ZERO + v[CHAR_WIDTH-1:0];
    end
    if ($urandom_range(0, 1) == 1) begin
      return CH_LOWER_A + v[CHAR_WIDTH-1:0] - LETTER_OFFSET;
    end
    return CH_UPPER_A + v[CHAR_WIDTH-1:0] - LETTER_OFFSET;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] noise_char();
    case ($urandom_range(0, 5))
      0: return CH_BIN;
      1: return CH_DEC;
      2: return CH_HEX;
      default: return CHAR_WIDTH'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_random_token();
    int unsigned kind;
    int unsigned n;
    int unsigned radix;
    kind  = $urandom_range(0, 99);
    radix = base_setting;
    token_buf.delete();
    if (kind < 8) begin
      token_buf.push_back(CH_QUOTE);
      token_buf.push_back(CHAR_WIDTH'($urandom_range(0, 127)));
      if (kind != 0) begin
        token_buf.push_back((kind == 1) ? noise_char() : CH_QUOTE);
      end
      if (kind == 2) begin
        token_buf.push_back(random_digit(radix));
      end
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        token_buf.push_back(CH_BIN);
        radix = BASE_BIN;
      end
      if ($urandom_range(0, 3) == 0) begin
        token_buf.push_back(CH_DEC);
        radix = BASE_DEC;
      end
      if ($urandom_range(0, 3) == 0) begin
        token_buf.push_back(CH_HEX);
        radix = BASE_HEX;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
      repeat (n) token_buf.push_back(random_digit(radix));
      if (token_buf.size() == 0) begin
        token_buf.push_back(random_digit(radix));
      end
      if (kind >= 88) begin
        token_buf[$urandom_range(0, token_buf.size() - 1)] = noise_char();
      end
    end
    foreach (token_buf[i]) begin
      send_char(token_buf[i], i == token_buf.size() - 1);
    end
  endtask

  task automatic test_directed_tokens();
    send_string("%10");
    send_string("$fF");
    send_string("%#$");
    send_string("#%");
    send_char(CH_QUOTE, 1'b0);
    send_char(7'd0, 1'b0);
    send_char(CH_QUOTE, 1'b1);
    send_string("'a''");
    send_char(7'd127, 1'b1);
    send_char(7'd0, 1'b1);
    send_string("z");
    send_string("9");
  endtask

  task automatic test_default_base_extremes();
    logic [BASE_WIDTH-1:0] bases[6];
    bases = '{6'd2, 6'd36, 6'd0, 6'd1, 6'd63, 6'd37};
    foreach (bases[i]) begin
      write_base(bases[i]);
      send_string("10");
      send_string("Zz");
      send_string("1");
      send_string("zzzzzzzzz");
    end
  endtask

  task automatic test_output_backpressure();
    write_base(BASE_DEC);
    tx_idle_pct = 0;
    hold_req    = 120;
    repeat (40) send_string("7");
    tx_idle_pct = 38;
  endtask

  task automatic test_random_tokens();
    logic [BASE_WIDTH-1:0] bases[10];
    int unsigned           phase_end;
    bases = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd63, 6'd37, 6'd8, 6'd10};
    foreach (bases[p]) begin
      write_base((p == 9) ? 6'($urandom_range(2, 36)) : bases[p]);
      tx_idle_pct = (p == 3) ? 0 : 38;
      rx_idle_pct = (p == 3) ? 0 : 38;
      phase_end   = chars_sent + 130;
      while (chars_sent < phase_end) send_random_token();
    end
    tx_idle_pct = 38;
    rx_idle_pct = 38;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_tokens();
    test_default_base_extremes();
    test_output_backpressure();
    test_random_tokens();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
